// File: hdl/lptsc_pkg.sv
// shared types and constants for the length-prefix to start-code converter
`default_nettype none
package lptsc_pkg;

  localparam int unsigned PREFIX_BYTES      = 4;
  localparam int unsigned PREFIX_POS_W      = 2;
  localparam int unsigned LENGTH_W          = 32;
  localparam int unsigned GATHER_W          = LENGTH_W - 8;
  localparam logic [7:0]  START_ZERO_BYTE   = 8'h00;
  localparam logic [7:0]  START_LAST_BYTE   = 8'h01;
  localparam logic [PREFIX_POS_W-1:0] PREFIX_LAST_POS = PREFIX_POS_W'(PREFIX_BYTES - 1);
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  // per-frame parsing mode
  typedef enum logic [1:0] {
    MODE_DECIDE  = 2'd0,
    MODE_CONVERT = 2'd1,
    MODE_PASS    = 2'd2
  } mode_t;

  // what the back end puts on the output byte
  typedef enum logic [1:0] {
    CLS_START_ZERO = 2'd0,
    CLS_START_LAST = 2'd1,
    CLS_DATA       = 2'd2
  } byte_cls_t;

  // one classified item travelling from front to back
  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
    logic       last;
    logic       truncated;
  } q_item_t;

endpackage
`default_nettype wire

// File: hdl/lptsc_if.sv
// valid/ready channel interfaces for the input and result items
`default_nettype none
interface lptsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lptsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       truncated;

  modport source (output valid, output out_byte, output out_last, output truncated,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input truncated,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/length_prefix_to_start_code.sv
// top level: length-prefixed frame bytes in, start-code frame bytes out
// an accepted input item is written into the item queue and then registered in the result register
// throughput: one item per cycle while the queue has room, set by the prefix/payload state update
// the item queue buffers up to QUEUE_DEPTH items while the output stalls
// reset: synchronous active-low rst_n empties the queue and result register and returns
// the parser to deciding on the first prefix of a new frame
`default_nettype none
module length_prefix_to_start_code #(
  parameter int unsigned QUEUE_DEPTH = lptsc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lptsc_in_if.sink      in_ch,
  lptsc_out_if.source   out_ch
);

  lptsc_pkg::q_item_t push_item;
  lptsc_pkg::q_item_t pop_item;
  logic               push, full, pop, not_empty;

  // parse and classify
  lptsc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (full),
    .q_push_item (push_item),
    .q_push      (push)
  );

  // decoupling queue
  lptsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  // output formation
  lptsc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_pop_item  (pop_item),
    .q_pop       (pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// File: hdl/lptsc_front.sv
// front end: accepts frame bytes, tracks prefix/payload state, classifies each item
`default_nettype none
module lptsc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lptsc_in_if.sink               in_ch,
  input  wire logic              q_full,
  output lptsc_pkg::q_item_t     q_push_item,
  output logic                   q_push
);

  lptsc_pkg::mode_t                        mode_r, mode_nxt;
  logic [lptsc_pkg::PREFIX_POS_W-1:0]      pos_r, pos_nxt;
  logic [lptsc_pkg::GATHER_W-1:0]          gather_r, gather_nxt;
  logic [lptsc_pkg::LENGTH_W-1:0]          left_r, left_nxt;
  logic [lptsc_pkg::LENGTH_W-1:0]          full_len;
  logic                                    in_prefix;
  logic                                    trunc;

  assign in_ch.ready = ~q_full;
  assign q_push      = in_ch.valid & ~q_full;

  // length as it stands once this byte is appended
  assign full_len  = {gather_r, in_ch.in_byte};
  assign in_prefix = (mode_r == lptsc_pkg::MODE_DECIDE) ||
                     ((mode_r == lptsc_pkg::MODE_CONVERT) && (left_r == '0));

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    gather_nxt = gather_r;
    left_nxt   = left_r;
    if (in_prefix) begin
      if (pos_r == lptsc_pkg::PREFIX_LAST_POS) begin
        pos_nxt    = '0;
        gather_nxt = '0;
        if ((mode_r == lptsc_pkg::MODE_DECIDE) && (full_len == lptsc_pkg::LENGTH_W'(1))) begin
          mode_nxt = lptsc_pkg::MODE_PASS;
          left_nxt = '0;
        end else begin
          mode_nxt = lptsc_pkg::MODE_CONVERT;
          left_nxt = full_len;
        end
      end else begin
        pos_nxt    = pos_r + lptsc_pkg::PREFIX_POS_W'(1);
        gather_nxt = full_len[lptsc_pkg::GATHER_W-1:0];
      end
    end else begin
      unique case (mode_r)
        lptsc_pkg::MODE_CONVERT: left_nxt = left_r - lptsc_pkg::LENGTH_W'(1);
        default:                 left_nxt = left_r;
      endcase
    end
  end

  // classification and truncation flag
  always_comb begin
    q_push_item.data = in_ch.in_byte;
    q_push_item.last = in_ch.in_last;
    trunc            = 1'b0;
    if (in_prefix) begin
      if (pos_r == lptsc_pkg::PREFIX_LAST_POS) begin
        q_push_item.cls = lptsc_pkg::CLS_START_LAST;
        trunc = ~((mode_r == lptsc_pkg::MODE_DECIDE) &&
                  (full_len == lptsc_pkg::LENGTH_W'(1))) && (full_len != '0);
      end else begin
        q_push_item.cls = lptsc_pkg::CLS_START_ZERO;
        trunc = 1'b1;
      end
    end else begin
      q_push_item.cls = lptsc_pkg::CLS_DATA;
      unique case (mode_r)
        lptsc_pkg::MODE_CONVERT: trunc = (left_r != lptsc_pkg::LENGTH_W'(1));
        default:                 trunc = 1'b0;
      endcase
    end
    q_push_item.truncated = in_ch.in_last & trunc;
  end

  // state registers, back to reset values after the last byte of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lptsc_pkg::MODE_DECIDE;
      pos_r    <= '0;
      gather_r <= '0;
      left_r   <= '0;
    end else if (q_push) begin
      if (in_ch.in_last) begin
        mode_r   <= lptsc_pkg::MODE_DECIDE;
        pos_r    <= '0;
        gather_r <= '0;
        left_r   <= '0;
      end else begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        gather_r <= gather_nxt;
        left_r   <= left_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/lptsc_queue.sv
// short fifo of classified items between front and back
`default_nettype none
module lptsc_queue #(
  parameter int unsigned DEPTH = lptsc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lptsc_pkg::q_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output lptsc_pkg::q_item_t      pop_item,
  output logic                    not_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lptsc_pkg::q_item_t   mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_item  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/lptsc_back.sv
// back end: forms the output byte from the item class and holds the result register
`default_nettype none
module lptsc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_not_empty,
  input  wire lptsc_pkg::q_item_t q_pop_item,
  output logic                   q_pop,
  lptsc_out_if.source            out_ch
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r;
  logic       trunc_r;

  // take a new item whenever the result register is empty or being drained
  assign q_pop = q_not_empty & (~valid_r | out_ch.ready);

  // start code byte or payload byte
  always_comb begin
    unique case (q_pop_item.cls)
      lptsc_pkg::CLS_START_ZERO: byte_nxt = lptsc_pkg::START_ZERO_BYTE;
      lptsc_pkg::CLS_START_LAST: byte_nxt = lptsc_pkg::START_LAST_BYTE;
      default:                   byte_nxt = q_pop_item.data;
    endcase
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r  <= byte_nxt;
      last_r  <= q_pop_item.last;
      trunc_r <= q_pop_item.truncated;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.out_last  = last_r;
  assign out_ch.truncated = trunc_r;

endmodule
`default_nettype wire
